// File: rtl/qpcd_pkg.sv
// Package for the box QP coordinate descent solver.
// Holds the sequencer states, input modes, status and register codes, and saturation helpers.
// Used by qpcd_div and box_qp_clipped_coordinate_descent.
package qpcd_pkg;

  localparam int DVD_W  = 64;
  localparam int DVS_W  = 32;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  localparam logic [2:0] MODE_H     = 3'd0;
  localparam logic [2:0] MODE_Q     = 3'd1;
  localparam logic [2:0] MODE_LB    = 3'd2;
  localparam logic [2:0] MODE_UB    = 3'd3;
  localparam logic [2:0] MODE_START = 3'd4;

  localparam logic [1:0] STAT_CONV   = 2'd0;
  localparam logic [1:0] STAT_NOELIG = 2'd1;
  localparam logic [1:0] STAT_LIMIT  = 2'd2;
  localparam logic [1:0] STAT_ZDIAG  = 2'd3;

  localparam logic [1:0] REG_DIM   = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT_RD,
    S_INIT_WR,
    S_LOOP,
    S_K_RD,
    S_K_MUL,
    S_K_ACC,
    S_G_RD,
    S_G_CALC,
    S_SQ,
    S_DIV_STEP,
    S_DIV_GAIN,
    S_DECIDE,
    S_UPD_RD,
    S_UPD_WR,
    S_OUT_RD,
    S_OUT_EM
  } qpcd_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = 32'sh7FFFFFFF;
    else if (x < S32_MIN) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// File: rtl/qpcd_div.sv
// Iterative signed divider, one quotient bit per cycle, quotient truncated toward zero.
// Depends on qpcd_pkg for operand widths.
module qpcd_div import qpcd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic signed [DVS_W-1:0] divisor,
  output logic                    done,
  output logic signed [DVD_W-1:0] quotient
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic              neg_r;

  logic [DVS_W:0] rem_sh;
  logic           ge;
  logic [DVS_W:0] rem_n;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign rem_n  = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      dvs_r <= divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
      neg_r <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_n[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(dvd_r) : $signed(dvd_r);

endmodule

// File: rtl/box_qp_clipped_coordinate_descent.sv
// Top level of the box QP clipped coordinate descent solver.
// Depends on qpcd_pkg and qpcd_div.
//
// Usage: load transactions (start high, busy low, in_mode 0..3) write H(row,col), q, lb or
// ub and leave busy low. A start transaction (in_mode 4) raises busy for the whole solve.
// Modes 5..7 are accepted and ignored. Configuration writes (cfg_we, cfg_index, cfg_data) take
// effect at once; the user must make them while busy is low, as the block does not enforce it.
// Solve sequence with n coordinates in use: initialization reads and writes each coordinate in turn;
// each update step computes every gradient with the single multiplier, reading one H entry at a
// time through read, multiply and accumulate states, and runs the bit-serial divider twice per
// coordinate, for the step and for the gain quotient.
// After the solve, n results leave on out_valid, each carrying index, solution, last, status
// and steps_used; busy drops after the last one.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Reset returns the sequencer to idle and the registers to dimension 32, tolerance 66,
// step limit 1000. The H, q, lb and ub stores are not cleared and must be loaded before use.
module box_qp_clipped_coordinate_descent import qpcd_pkg::*; #(
  parameter int MAX_DIM   = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_mode,
  input  logic [4:0]         in_row,
  input  logic [4:0]         in_col,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [4:0]         out_index,
  output logic signed [31:0] out_solution,
  output logic               out_last,
  output logic [1:0]         out_status,
  output logic [15:0]        out_steps_used,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int IDXW   = $clog2(MAX_DIM);
  localparam int NW     = $clog2(MAX_DIM + 1);
  localparam int HDEPTH = MAX_DIM * MAX_DIM;
  localparam int HAW    = $clog2(HDEPTH);

  qpcd_state_t state_r, state_nxt;

  logic [5:0]  dim_r;
  logic [30:0] tol_r;
  logic [15:0] step_limit_r;

  logic signed [31:0] h_mem  [HDEPTH];
  logic signed [31:0] q_mem  [MAX_DIM];
  logic signed [31:0] lb_mem [MAX_DIM];
  logic signed [31:0] ub_mem [MAX_DIM];
  logic signed [31:0] u_mem  [MAX_DIM];

  logic signed [31:0] h_rd_r, q_rd_r, lb_rd_r, ub_rd_r, u_rd_r;

  logic [NW-1:0]   n_r;
  logic [IDXW-1:0] j_r, k_r, best_idx_r;
  logic            zero_r, have_best_r;
  logic [1:0]      status_r;
  logic [15:0]     steps_r;
  logic signed [63:0] acc_r, prod_r;
  logic signed [31:0] g_r, d_r, uj_r, lbj_r, ubj_r;
  logic signed [31:0] step_r, best_all_r, best_gain_r, best_step_r;

  logic            acc_tr, wr_ok;
  logic [IDXW-1:0] vaddr, hrow, hcol;
  logic [HAW-1:0]  haddr, haddr_w;
  logic            u_we;
  logic [IDXW-1:0] u_waddr;
  logic signed [31:0] u_wdata;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_c;
  logic            div_start, div_done;
  logic signed [63:0] div_dvd, div_quot;
  logic [NW-1:0]   n_calc;
  logic            j_last, k_last;
  logic signed [31:0] gain_c, start_u, upd_u;
  logic signed [63:0] lo_c, hi_c, lam_c;
  logic            elig_c, zero_c;

  assign busy   = (state_r != S_IDLE);
  assign acc_tr = start && !busy;
  assign wr_ok  = (32'(in_row) < 32'(MAX_DIM)) && (in_mode != MODE_H || 32'(in_col) < 32'(MAX_DIM));

  assign n_calc = (dim_r == 6'd0) ? NW'(1) :
                  (32'(dim_r) > 32'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(dim_r);
  assign j_last = (NW'(j_r) == n_r - NW'(1));
  assign k_last = (NW'(k_r) == n_r - NW'(1));

  assign haddr   = HAW'(hrow) * HAW'(MAX_DIM) + HAW'(hcol);
  assign haddr_w = HAW'(in_row) * HAW'(MAX_DIM) + HAW'(in_col);

  assign prod_c  = mul_a * mul_b;
  assign start_u = 32'((64'(lb_rd_r) + 64'(ub_rd_r)) >>> 1);
  assign zero_c  = zero_r || (h_rd_r == 32'sd0);
  assign gain_c  = sat32(div_quot);
  assign elig_c  = (uj_r > lbj_r && step_r < 32'sd0) || (uj_r < ubj_r && step_r > 32'sd0);

  always_comb begin
    lo_c  = 64'(lb_rd_r) - 64'(u_rd_r);
    hi_c  = 64'(ub_rd_r) - 64'(u_rd_r);
    lam_c = 64'(best_step_r);
    if (hi_c < lam_c) lam_c = hi_c;
    if (lo_c > lam_c) lam_c = lo_c;
    upd_u = sat32(64'(u_rd_r) + lam_c);
  end

  qpcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    vaddr     = j_r;
    hrow      = j_r;
    hcol      = j_r;
    u_we      = 1'b0;
    u_waddr   = j_r;
    u_wdata   = start_u;
    mul_a     = u_rd_r;
    mul_b     = h_rd_r;
    div_start = 1'b0;
    div_dvd   = prod_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_tr && in_mode == MODE_START) state_nxt = S_INIT_RD;
      end
      S_INIT_RD: state_nxt = S_INIT_WR;
      S_INIT_WR: begin
        u_we = 1'b1;
        if (!j_last) state_nxt = S_INIT_RD;
        else if (zero_c) state_nxt = S_OUT_RD;
        else state_nxt = S_LOOP;
      end
      S_LOOP: state_nxt = (steps_r >= step_limit_r) ? S_OUT_RD : S_K_RD;
      S_K_RD: begin
        vaddr     = k_r;
        hrow      = k_r;
        state_nxt = S_K_MUL;
      end
      S_K_MUL: state_nxt = S_K_ACC;
      S_K_ACC: state_nxt = k_last ? S_G_RD : S_K_RD;
      S_G_RD:  state_nxt = S_G_CALC;
      S_G_CALC: state_nxt = S_SQ;
      S_SQ: begin
        mul_a     = g_r;
        mul_b     = g_r;
        div_start = 1'b1;
        div_dvd   = {{32{g_r[31]}}, g_r} <<< FRAC_BITS;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = S_DIV_GAIN;
        end
      end
      S_DIV_GAIN: begin
        if (div_done) state_nxt = j_last ? S_DECIDE : S_K_RD;
      end
      S_DECIDE: begin
        if (best_all_r < $signed({1'b0, tol_r})) state_nxt = S_OUT_RD;
        else if (!have_best_r) state_nxt = S_OUT_RD;
        else state_nxt = S_UPD_RD;
      end
      S_UPD_RD: begin
        vaddr     = best_idx_r;
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        u_we      = 1'b1;
        u_waddr   = best_idx_r;
        u_wdata   = upd_u;
        state_nxt = S_LOOP;
      end
      S_OUT_RD: state_nxt = S_OUT_EM;
      S_OUT_EM: state_nxt = j_last ? S_IDLE : S_OUT_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r        <= 6'd32;
      tol_r        <= 31'd66;
      step_limit_r <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM:   dim_r        <= cfg_data[5:0];
        REG_TOL:   tol_r        <= cfg_data;
        REG_LIMIT: step_limit_r <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc_tr && wr_ok) begin
      case (in_mode)
        MODE_H:  h_mem[haddr_w] <= in_value;
        MODE_Q:  q_mem[IDXW'(in_row)] <= in_value;
        MODE_LB: lb_mem[IDXW'(in_row)] <= in_value;
        MODE_UB: ub_mem[IDXW'(in_row)] <= in_value;
        default: ;
      endcase
    end
    if (u_we) u_mem[u_waddr] <= u_wdata;
    h_rd_r  <= h_mem[haddr];
    q_rd_r  <= q_mem[vaddr];
    lb_rd_r <= lb_mem[vaddr];
    ub_rd_r <= ub_mem[vaddr];
    u_rd_r  <= u_mem[vaddr];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        n_r     <= n_calc;
        j_r     <= '0;
        zero_r  <= 1'b0;
        steps_r <= '0;
      end
      S_INIT_WR: begin
        zero_r <= zero_c;
        if (j_last) begin
          j_r <= '0;
          if (zero_c) status_r <= STAT_ZDIAG;
        end else begin
          j_r <= j_r + IDXW'(1);
        end
      end
      S_LOOP: begin
        j_r         <= '0;
        k_r         <= '0;
        acc_r       <= '0;
        have_best_r <= 1'b0;
        if (steps_r >= step_limit_r) status_r <= STAT_LIMIT;
      end
      S_K_MUL: prod_r <= prod_c;
      S_K_ACC: begin
        acc_r <= acc_r + (prod_r >>> FRAC_BITS);
        k_r   <= k_r + IDXW'(1);
      end
      S_G_CALC: begin
        g_r   <= sat32(64'(q_rd_r) - acc_r);
        d_r   <= h_rd_r;
        uj_r  <= u_rd_r;
        lbj_r <= lb_rd_r;
        ubj_r <= ub_rd_r;
      end
      S_SQ: prod_r <= prod_c;
      S_DIV_STEP: begin
        if (div_done) step_r <= gain_c;
      end
      S_DIV_GAIN: begin
        if (div_done) begin
          if (j_r == '0 || gain_c > best_all_r) best_all_r <= gain_c;
          if (elig_c && (!have_best_r || gain_c > best_gain_r)) begin
            have_best_r <= 1'b1;
            best_idx_r  <= j_r;
            best_gain_r <= gain_c;
            best_step_r <= step_r;
          end
          j_r   <= j_last ? '0 : j_r + IDXW'(1);
          k_r   <= '0;
          acc_r <= '0;
        end
      end
      S_DECIDE: begin
        if (best_all_r < $signed({1'b0, tol_r})) status_r <= STAT_CONV;
        else if (!have_best_r) status_r <= STAT_NOELIG;
      end
      S_UPD_WR: steps_r <= steps_r + 16'd1;
      S_OUT_EM: j_r <= j_r + IDXW'(1);
      default: ;
    endcase
  end

  assign out_valid      = (state_r == S_OUT_EM);
  assign out_index      = 5'(j_r);
  assign out_solution   = u_rd_r;
  assign out_last       = j_last;
  assign out_status     = status_r;
  assign out_steps_used = steps_r;

`ifndef NO_ASSERTIONS
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("result strobe while idle");
  a_zdiag_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_ZDIAG) |-> (out_steps_used == 16'd0))
    else $error("zero diagonal with steps taken");
  a_limit_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_LIMIT) |-> (out_steps_used == step_limit_r))
    else $error("step limit status with wrong count");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_START) |=> busy)
    else $error("start transaction did not raise busy");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_STEP || state_r == S_DIV_GAIN))
    else $error("divider result not awaited");
`endif

endmodule

// File: bench/tb_box_qp_clipped_coordinate_descent.sv
// Testbench for box_qp_clipped_coordinate_descent: loads H, q, lb and ub, starts solves and
// checks every emitted solution element against a fixed-point coordinate descent predictor.
// Depends on qpcd_pkg and the solver RTL.
module tb_box_qp_clipped_coordinate_descent import qpcd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_MAX = 32;
  localparam int IDLE_LIMIT = 400000;

  typedef struct {
    logic [4:0]         index;
    logic signed [31:0] solution;
    logic               last;
    logic [1:0]         status;
    logic [15:0]        steps_used;
  } qp_elem_t;

  class qp_scoreboard;
    int hmat[DIM_MAX][DIM_MAX];
    int qvec[DIM_MAX];
    int lbvec[DIM_MAX];
    int ubvec[DIM_MAX];
    int uvec[DIM_MAX];
    int unsigned dim_reg = 32;
    int unsigned tol_reg = 66;
    int unsigned lim_reg = 1000;
    qp_elem_t solution_q[$];
    int errors = 0;
    int results = 0;

    function void set_cfg(logic [1:0] idx, logic [30:0] data);
      if (idx == REG_DIM) dim_reg = data[5:0];
      else if (idx == REG_TOL) tol_reg = data;
      else if (idx == REG_LIMIT) lim_reg = data[15:0];
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function int pending();
      return solution_q.size();
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function void descend(int n, output logic [1:0] st, output int steps);
      int stepv[DIM_MAX];
      longint gain[DIM_MAX];
      longint acc, g, d, best_all, best_gain, u, lo, hi, lam;
      int best;
      bit done;
      for (int j = 0; j < n; j++)
        uvec[j] = int'((longint'(lbvec[j]) + longint'(ubvec[j])) >>> 1);
      steps = 0;
      st = STAT_CONV;
      done = 0;
      for (int j = 0; j < n; j++)
        if (hmat[j][j] == 0) begin
          st = STAT_ZDIAG;
          done = 1;
        end
      while (!done) begin
        if (steps >= lim_reg) begin
          st = STAT_LIMIT;
          break;
        end
        for (int j = 0; j < n; j++) begin
          acc = 0;
          d = hmat[j][j];
          for (int k = 0; k < n; k++)
            acc += (longint'(uvec[k]) * longint'(hmat[k][j])) >>> 16;
          g = clip32(longint'(qvec[j]) - acc);
          stepv[j] = int'(clip32((g <<< 16) / d));
          gain[j] = clip32((g * g) / d);
        end
        best_all = gain[0];
        for (int j = 1; j < n; j++)
          if (gain[j] > best_all) best_all = gain[j];
        if (best_all < longint'(tol_reg)) begin
          st = STAT_CONV;
          break;
        end
        best = -1;
        best_gain = 0;
        for (int j = 0; j < n; j++)
          if (((uvec[j] > lbvec[j] && stepv[j] < 0) || (uvec[j] < ubvec[j] && stepv[j] > 0))
              && (best < 0 || gain[j] > best_gain)) begin
            best = j;
            best_gain = gain[j];
          end
        if (best < 0) begin
          st = STAT_NOELIG;
          break;
        end
        u = uvec[best];
        lo = longint'(lbvec[best]) - u;
        hi = longint'(ubvec[best]) - u;
        lam = stepv[best];
        if (hi < lam) lam = hi;
        if (lo > lam) lam = lo;
        uvec[best] = int'(clip32(u + lam));
        steps++;
      end
    endfunction

    function void note_input(logic [2:0] m, logic [4:0] r, logic [4:0] c, logic [31:0] v);
      int n, steps;
      logic [1:0] st;
      qp_elem_t e;
      case (m)
        MODE_H: hmat[r][c] = v;
        MODE_Q: qvec[r] = v;
        MODE_LB: lbvec[r] = v;
        MODE_UB: ubvec[r] = v;
        MODE_START: begin
          n = dim_reg;
          if (n < 1) n = 1;
          if (n > DIM_MAX) n = DIM_MAX;
          descend(n, st, steps);
          for (int j = 0; j < n; j++) begin
            e.index = j;
            e.solution = uvec[j];
            e.last = (j == n - 1);
            e.status = st;
            e.steps_used = steps[15:0];
            solution_q.push_back(e);
          end
        end
        default: ;
      endcase
    endfunction

    task check(logic [4:0] idx, logic [31:0] sol, logic lst, logic [1:0] st, logic [15:0] su);
      qp_elem_t e;
      results++;
      if (solution_q.size() == 0) begin
        report("unexpected result, index", idx, -1);
        return;
      end
      e = solution_q.pop_front();
      if (idx !== e.index) report("index", idx, e.index);
      if (sol !== e.solution) report("solution", $signed(sol), e.solution);
      if (lst !== e.last) report("last", lst, e.last);
      if (st !== e.status) report("status", st, e.status);
      if (su !== e.steps_used) report("steps_used", su, e.steps_used);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [2:0] in_mode = '0;
  logic [4:0] in_row = '0;
  logic [4:0] in_col = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic [4:0] out_index;
  logic signed [31:0] out_solution;
  logic out_last;
  logic [1:0] out_status;
  logic [15:0] out_steps_used;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  qp_scoreboard sb = new();
  bit h_wr[DIM_MAX][DIM_MAX];
  bit q_wr[DIM_MAX];
  bit lb_wr[DIM_MAX];
  bit ub_wr[DIM_MAX];
  int idle_pct = 0;
  int items = 0;
  int cur_n = 32;
  int idle_cnt = 0;

  box_qp_clipped_coordinate_descent dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_row(in_row), .in_col(in_col), .in_value(in_value),
    .out_valid(out_valid), .out_index(out_index), .out_solution(out_solution),
    .out_last(out_last), .out_status(out_status), .out_steps_used(out_steps_used),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check(out_index, out_solution, out_last, out_status, out_steps_used);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(input logic [2:0] m, input logic [4:0] r, input logic [4:0] c,
                      input logic [31:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 0;
    end
    @(negedge clk);
    start = 1;
    in_mode = m;
    in_row = r;
    in_col = c;
    in_value = v;
    do @(posedge clk); while (busy);
    sb.note_input(m, r, c, v);
    case (m)
      MODE_H: h_wr[r][c] = 1;
      MODE_Q: q_wr[r] = 1;
      MODE_LB: lb_wr[r] = 1;
      MODE_UB: ub_wr[r] = 1;
      default: ;
    endcase
    items++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [30:0] data);
    drain();
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    sb.set_cfg(idx, data);
    @(negedge clk);
    cfg_we = 0;
    if (idx == REG_DIM) begin
      cur_n = data[5:0];
      if (cur_n < 1) cur_n = 1;
      if (cur_n > DIM_MAX) cur_n = DIM_MAX;
    end
  endtask

  function automatic logic [31:0] diag_val();
    return $urandom_range(65536, 262144);
  endfunction

  function automatic logic [31:0] offd_val();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  task automatic put_bounds(input int j);
    int lo;
    lo = -int'($urandom_range(0, 196608));
    send(MODE_LB, j, 0, lo);
    send(MODE_UB, j, 0, lo + int'($urandom_range(0, 262144)));
  endtask

  task automatic fill(input int n);
    for (int j = 0; j < n; j++) begin
      for (int k = 0; k < n; k++)
        if (!h_wr[j][k]) send(MODE_H, j, k, (j == k) ? diag_val() : offd_val());
      if (!q_wr[j]) send(MODE_Q, j, 0, int'($urandom_range(0, 524288)) - 262144);
      if (!lb_wr[j] || !ub_wr[j]) put_bounds(j);
    end
  endtask

  task automatic noise_item();
    logic [2:0] m;
    m = $urandom_range(0, 7);
    if (m == MODE_START) m = 3'd5 + 3'($urandom_range(0, 2));
    send(m, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
  endtask

  task automatic solve_item();
    int j, k, lim;
    if ($urandom_range(0, 2) == 0) begin
      cfg_write(REG_DIM, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6)
                                                       : $urandom_range(1, 4));
      cfg_write(REG_TOL, ($urandom_range(0, 4) == 0) ? 31'($urandom) : $urandom_range(0, 100));
      lim = (cur_n > 4) ? $urandom_range(0, 6) : $urandom_range(0, 25);
      cfg_write(REG_LIMIT, lim);
    end
    repeat ($urandom_range(1, 4)) begin
      j = $urandom_range(0, cur_n - 1);
      k = $urandom_range(0, cur_n - 1);
      case ($urandom_range(0, 5))
        0: send(MODE_H, j, k, (j == k) ? diag_val() : offd_val());
        1: send(MODE_H, j, j, ($urandom_range(0, 5) == 0) ? 32'd0 : -int'(diag_val()));
        2: send(MODE_Q, j, 0, int'($urandom_range(0, 1048576)) - 524288);
        3: send(MODE_Q, j, 0, $urandom);
        default: put_bounds(j);
      endcase
    end
    fill(cur_n);
    send(MODE_START, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    cfg_write(REG_DIM, 2);
    cfg_write(REG_TOL, 0);
    cfg_write(REG_LIMIT, 10);
    send(MODE_H, 0, 0, 131072);
    send(MODE_H, 0, 1, 32'h80000000);
    send(MODE_H, 1, 0, 32'h7FFFFFFF);
    send(MODE_H, 1, 1, 65536);
    send(MODE_Q, 0, 0, 32'h7FFFFFFF);
    send(MODE_Q, 1, 0, 32'h80000000);
    send(MODE_LB, 0, 0, 32'h80000000);
    send(MODE_UB, 0, 0, 32'h7FFFFFFF);
    send(MODE_LB, 1, 0, 65536);
    send(MODE_UB, 1, 0, -65536);
    send(MODE_START, 0, 0, 0);
    send(MODE_H, 1, 1, 0);
    send(MODE_START, 31, 31, 32'hFFFFFFFF);
    send(MODE_H, 1, 1, 65536);
    send(3'd5, 31, 31, 0);
    send(3'd6, 0, 0, 32'hFFFFFFFF);
    send(3'd7, 10, 21, 32'h55555555);
    cfg_write(REG_LIMIT, 0);
    send(MODE_START, 0, 0, 0);
    cfg_write(REG_LIMIT, 65535);
    send(MODE_H, 0, 1, 0);
    send(MODE_H, 1, 0, 0);
    send(MODE_Q, 0, 0, 65536);
    send(MODE_Q, 1, 0, -65536);
    send(MODE_LB, 1, 0, 0);
    send(MODE_UB, 1, 0, 0);
    send(MODE_LB, 0, 0, 0);
    send(MODE_UB, 0, 0, 0);
    send(MODE_START, 0, 0, 0);
    cfg_write(REG_TOL, 31'h7FFFFFFF);
    send(MODE_START, 0, 0, 0);
    cfg_write(REG_DIM, 0);
    send(MODE_START, 0, 0, 0);
    cfg_write(REG_DIM, 3);
    cfg_write(REG_TOL, 0);
    cfg_write(REG_LIMIT, 10);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 32 : (ph == 1) ? 64 : 0;
      items = 0;
      while (items < 27) begin
        if ($urandom_range(0, 4) == 0) noise_item();
        else solve_item();
      end
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
